FILE: rtl/core/aipq_pkg.sv
package aipq_pkg;

	localparam int CAPACITY      = 64;
	localparam int NODE_BITS     = 16;
	localparam int PRIORITY_BITS = 32;
	localparam int STAMP_W       = 32;
	localparam int IDX_W         = $clog2(CAPACITY);
	localparam int CNT_W         = $clog2(CAPACITY + 1);
	localparam int SUM_W         = (PRIORITY_BITS > 32 ? PRIORITY_BITS : 32) + 1;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_POP    = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]         operation;
		logic [15:0]        from_node;
		logic [15:0]        to_node;
		logic signed [31:0] amount;
	} request_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               found;
		logic [15:0]        popped_from;
		logic [15:0]        popped_to;
		logic signed [31:0] priority_out;
		logic [6:0]         entry_count;
	} result_t;

	typedef logic signed [PRIORITY_BITS-1:0] prio_t;

	typedef struct packed {
		logic [NODE_BITS-1:0] from_node;
		logic [NODE_BITS-1:0] to_node;
		prio_t                prio;
		logic [STAMP_W-1:0]   stamp;
	} slot_t;

	localparam logic signed [SUM_W-1:0] PRIO_MAX =
		signed'({{(SUM_W - PRIORITY_BITS + 1){1'b0}}, {(PRIORITY_BITS - 1){1'b1}}});
	localparam logic signed [SUM_W-1:0] PRIO_MIN = -PRIO_MAX - SUM_W'(signed'(2'sd1));

	// exact sum clamped to the signed priority range
	function automatic prio_t sat_add(input prio_t base, input logic signed [31:0] amt);
		logic signed [SUM_W-1:0] sum;
		sum = SUM_W'(base) + SUM_W'(amt);
		if (sum > PRIO_MAX) begin
			sum = PRIO_MAX;
		end else if (sum < PRIO_MIN) begin
			sum = PRIO_MIN;
		end
		return signed'(sum[PRIORITY_BITS-1:0]);
	endfunction

endpackage

FILE: rtl/core/accumulating_indexed_priority_queue.sv
// Accumulating indexed max-priority queue, 64 slots keyed by (from_node, to_node).
// Request channel: drive request and raise start; the request is taken at the
// clock edge where start is high and busy is low. busy stays high until the
// request is done.
// Result channel: done pulses for one cycle with result valid in that cycle.
// The receiver cannot stall; a result not taken in its cycle is gone.
// Sequence: insert, query and pop scan every slot through one registered memory
// read port, one slot per cycle, then pass through S_DRAIN and S_FINISH; the
// result shows in the same cycle that busy drops. Clear needs no scan: it goes
// from S_IDLE straight to S_FINISH.
// Scanning requests are taken one at a time, a new one only after the last is
// done, set by the single memory read port and the one shared compare unit.
// A new request may be taken in the cycle its predecessor's result is shown.
// Reset (arst_n low) empties the table, zeroes the count and the update stamp;
// slot contents are kept in memory without reset and gated by valid flops.
module accumulating_indexed_priority_queue
	import aipq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_FINISH = 2'd3;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	logic [1:0]          state_q;
	request_t            req_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic                chk_vld_s1;
	logic [IDX_W-1:0]    chk_idx_s1;
	slot_t               rdata_s1;
	slot_t               mem [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [STAMP_W-1:0]  counter_q;

	logic                match_hit_q;
	logic [IDX_W-1:0]    match_idx_q;
	prio_t               match_prio_q;
	logic                free_hit_q;
	logic [IDX_W-1:0]    free_idx_q;
	logic                best_hit_q;
	logic [IDX_W-1:0]    best_idx_q;
	slot_t               best_q;
	logic [STAMP_W-1:0]  best_age_q;

	logic                done_q;
	result_t             result_q;

	logic [NODE_BITS-1:0] key_from;
	logic [NODE_BITS-1:0] key_to;
	logic                 slot_live;
	logic [STAMP_W-1:0]   age;
	logic                 take_best;
	prio_t                sum_prio;
	logic                 mem_we;
	logic [IDX_W-1:0]     wr_idx;
	slot_t                wr_data;
	result_t              fin_result;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	assign key_from  = NODE_BITS'(req_q.from_node);
	assign key_to    = NODE_BITS'(req_q.to_node);
	assign slot_live = chk_vld_s1 && valid_q[chk_idx_s1];
	assign age       = counter_q - rdata_s1.stamp;

	// shared compare unit: larger priority wins, ties go to the smaller age
	always_comb begin
		take_best = !best_hit_q || (rdata_s1.prio > best_q.prio) ||
			((rdata_s1.prio == best_q.prio) && (age < best_age_q));
	end

	always_comb begin
		sum_prio = sat_add(match_hit_q ? match_prio_q : '0, req_q.amount);
		mem_we   = (state_q == S_FINISH) && (req_q.operation == OP_INSERT) &&
			(match_hit_q || free_hit_q);
		wr_idx   = match_hit_q ? match_idx_q : free_idx_q;
		wr_data.from_node = key_from;
		wr_data.to_node   = key_to;
		wr_data.prio      = sum_prio;
		wr_data.stamp     = counter_q;
	end

	// result of the request once the scan is over
	always_comb begin
		fin_result = '0;
		unique case (req_q.operation)
			OP_INSERT: begin
				if (match_hit_q) begin
					fin_result.entry_count = 7'(count_q);
				end else if (free_hit_q) begin
					fin_result.entry_count = 7'(count_q + CNT_W'(1));
				end else begin
					fin_result.status      = ST_FULL;
					fin_result.entry_count = 7'(count_q);
				end
			end
			OP_QUERY: begin
				fin_result.found        = match_hit_q;
				fin_result.priority_out = match_hit_q ? 32'(match_prio_q) : '0;
				fin_result.entry_count  = 7'(count_q);
			end
			OP_POP: begin
				if (best_hit_q) begin
					fin_result.found        = 1'b1;
					fin_result.popped_from  = 16'(best_q.from_node);
					fin_result.popped_to    = 16'(best_q.to_node);
					fin_result.priority_out = 32'(best_q.prio);
					fin_result.entry_count  = 7'(count_q - CNT_W'(1));
				end else begin
					fin_result.status      = ST_EMPTY;
					fin_result.entry_count = 7'(count_q);
				end
			end
			OP_CLEAR: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= '0;
			rd_addr_q   <= '0;
			chk_vld_s1  <= 1'b0;
			chk_idx_s1  <= '0;
			valid_q     <= '0;
			count_q     <= '0;
			counter_q   <= '0;
			match_hit_q <= 1'b0;
			match_idx_q <= '0;
			match_prio_q <= '0;
			free_hit_q  <= 1'b0;
			free_idx_q  <= '0;
			best_hit_q  <= 1'b0;
			best_idx_q  <= '0;
			best_q      <= '0;
			best_age_q  <= '0;
			done_q      <= 1'b0;
			result_q    <= '0;
		end else begin
			done_q     <= (state_q == S_FINISH);
			chk_vld_s1 <= (state_q == S_SCAN);
			chk_idx_s1 <= rd_addr_q;

			if (slot_live) begin
				if (rdata_s1.from_node == key_from && rdata_s1.to_node == key_to) begin
					match_hit_q  <= 1'b1;
					match_idx_q  <= chk_idx_s1;
					match_prio_q <= rdata_s1.prio;
				end
				if (take_best) begin
					best_hit_q <= 1'b1;
					best_idx_q <= chk_idx_s1;
					best_q     <= rdata_s1;
					best_age_q <= age;
				end
			end else if (chk_vld_s1 && !free_hit_q) begin
				free_hit_q <= 1'b1;
				free_idx_q <= chk_idx_s1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q       <= request;
						rd_addr_q   <= '0;
						match_hit_q <= 1'b0;
						free_hit_q  <= 1'b0;
						best_hit_q  <= 1'b0;
						state_q     <= (request.operation == OP_CLEAR) ? S_FINISH : S_SCAN;
					end
				end
				S_SCAN: begin
					rd_addr_q <= rd_addr_q + IDX_W'(1);
					if (rd_addr_q == LAST_IDX) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q  <= S_IDLE;
					result_q <= fin_result;
					unique case (req_q.operation)
						OP_INSERT: begin
							if (match_hit_q) begin
								counter_q <= counter_q + STAMP_W'(1);
							end else if (free_hit_q) begin
								valid_q[free_idx_q] <= 1'b1;
								count_q   <= count_q + CNT_W'(1);
								counter_q <= counter_q + STAMP_W'(1);
							end
						end
						OP_QUERY: begin
						end
						OP_POP: begin
							if (best_hit_q) begin
								valid_q[best_idx_q] <= 1'b0;
								count_q             <= count_q - CNT_W'(1);
							end
						end
						OP_CLEAR: begin
							valid_q <= '0;
							count_q <= '0;
						end
						default: begin
						end
					endcase
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/priority_queue_checker.sv
module priority_queue_checker
	import aipq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  request_t request,
	input  logic     done,
	input  result_t  result,
	output int       errors,
	output int       outstanding,
	output int       checked,
	output int       full_drops,
	output int       empty_pops
);
	timeunit 1ns;
	timeprecision 1ps;

	// shadow copy of the message table
	logic               occupied [CAPACITY];
	logic [15:0]        src      [CAPACITY];
	logic [15:0]        dst      [CAPACITY];
	logic signed [31:0] weight   [CAPACITY];
	logic [31:0]        age_mark [CAPACITY];
	logic [31:0]        touch_count;
	int                 live;

	result_t            pending_results [$];
	result_t            want;

	initial begin
		errors = 0;
		outstanding = 0;
		checked = 0;
		full_drops = 0;
		empty_pops = 0;
		touch_count = '0;
		live = 0;
		foreach (occupied[i]) occupied[i] = 1'b0;
	end

	function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s[31:0];
	endfunction

	function automatic int lookup(input logic [15:0] f, input logic [15:0] t);
		for (int i = 0; i < CAPACITY; i++) begin
			if (occupied[i] && src[i] == f && dst[i] == t) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic result_t apply_request(input request_t rq);
		result_t     r;
		int          k;
		int          best;
		logic [31:0] best_age;
		logic [31:0] slot_age;
		r = '0;
		case (rq.operation)
			OP_INSERT: begin
				k = lookup(rq.from_node, rq.to_node);
				if (k >= 0) begin
					weight[k] = clamp_add(weight[k], rq.amount);
					age_mark[k] = touch_count;
					touch_count++;
				end else begin
					for (int i = 0; i < CAPACITY && k < 0; i++) begin
						if (!occupied[i]) k = i;
					end
					if (k < 0) begin
						r.status = ST_FULL;
						full_drops++;
					end else begin
						occupied[k] = 1'b1;
						src[k] = rq.from_node;
						dst[k] = rq.to_node;
						weight[k] = rq.amount;
						age_mark[k] = touch_count;
						touch_count++;
						live++;
					end
				end
			end
			OP_QUERY: begin
				k = lookup(rq.from_node, rq.to_node);
				if (k >= 0) begin
					r.found = 1'b1;
					r.priority_out = weight[k];
				end
			end
			OP_POP: begin
				best = -1;
				best_age = '0;
				for (int i = 0; i < CAPACITY; i++) begin
					if (occupied[i]) begin
						// smaller distance from the update counter means more recent
						slot_age = touch_count - age_mark[i];
						if (best < 0 || weight[i] > weight[best] ||
							(weight[i] == weight[best] && slot_age < best_age)) begin
							best = i;
							best_age = slot_age;
						end
					end
				end
				if (best < 0) begin
					r.status = ST_EMPTY;
					empty_pops++;
				end else begin
					r.found = 1'b1;
					r.popped_from = src[best];
					r.popped_to = dst[best];
					r.priority_out = weight[best];
					occupied[best] = 1'b0;
					live--;
				end
			end
			OP_CLEAR: begin
				foreach (occupied[i]) occupied[i] = 1'b0;
				live = 0;
			end
		endcase
		r.entry_count = 7'(live);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, field, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t: result with no request outstanding, expected none, got %h",
						$time, result);
				end else begin
					want = pending_results.pop_front();
					compare_field("status", want.status, result.status);
					compare_field("found", want.found, result.found);
					compare_field("popped_from", want.popped_from, result.popped_from);
					compare_field("popped_to", want.popped_to, result.popped_to);
					compare_field("priority_out", want.priority_out, result.priority_out);
					compare_field("entry_count", want.entry_count, result.entry_count);
					checked++;
				end
			end
			if (start && !busy) begin
				pending_results.push_back(apply_request(request));
			end
			outstanding = pending_results.size();
		end
	end

endmodule

FILE: tb/accumulating_indexed_priority_queue_test.sv
module accumulating_indexed_priority_queue_test;
	timeunit 1ns;
	timeprecision 1ps;

	import aipq_pkg::*;

	localparam int REQUEST_TOTAL = 1650;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	request_t    request = '0;
	logic        busy;
	logic        done;
	result_t     result;

	int          errors;
	int          outstanding;
	int          checked;
	int          full_drops;
	int          empty_pops;

	int          issued = 0;
	int          op_tally [4] = '{default: 0};
	bit          quiet = 1'b0;
	logic [31:0] key_pool [8];
	logic [31:0] last_key = '0;

	always #4 clk = ~clk;

	accumulating_indexed_priority_queue u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	priority_queue_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.full_drops  (full_drops),
		.empty_pops  (empty_pops)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 4);
		return $urandom_range(5, 120);
	endfunction

	// Q16.16 deltas: small whole values make ties, extremes drive saturation
	function automatic logic [31:0] pick_amount();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return ($urandom_range(0, 8) - 4) * 32'h0001_0000;
		if (r < 60) return $urandom;
		if (r < 70) begin
			case ($urandom_range(0, 4))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'h0000_0000;
				3: return 32'hFFFF_FFFF;
				default: return 32'h0000_0001;
			endcase
		end
		return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
	endfunction

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// key packs {from_node, to_node}
	task automatic issue(input logic [1:0] op, input logic [31:0] key, input logic [31:0] amt);
		request_t rq;
		int       gap;
		rq.operation = op;
		rq.from_node = key[31:16];
		rq.to_node = key[15:0];
		rq.amount = amt;
		request <= rq;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		issued++;
		op_tally[op]++;
		gap = quiet ? 0 : pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int mode;
		int sel;
		int wait_cycles;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_POP, $urandom, $urandom);
		issue(OP_QUERY, 32'h0000_0000, $urandom);
		issue(OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
		issue(OP_INSERT, 32'h0000_0000, 32'h0000_0001);
		issue(OP_QUERY, 32'h0000_0000, $urandom);
		issue(OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
		issue(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		issue(OP_QUERY, 32'hFFFF_FFFF, $urandom);
		// equal maximum priorities: the later key must pop first
		issue(OP_INSERT, 32'hFFFF_0000, 32'h7FFF_FFFF);
		issue(OP_POP, $urandom, $urandom);
		issue(OP_POP, $urandom, $urandom);
		// an accumulation into a tie makes that key the newest
		issue(OP_INSERT, 32'h0000_FFFF, 32'hFFFB_0000);
		issue(OP_INSERT, 32'h0001_0001, 32'h0005_0000);
		issue(OP_INSERT, 32'h0000_FFFF, 32'h000A_0000);
		issue(OP_QUERY, 32'h0000_FFFF, $urandom);
		issue(OP_POP, $urandom, $urandom);
		issue(OP_INSERT, 32'h0001_0001, 32'h8000_0000);
		issue(OP_INSERT, 32'h1234_5678, 32'h0000_0000);
		issue(OP_CLEAR, $urandom, $urandom);
		issue(OP_QUERY, 32'hFFFF_FFFF, $urandom);
		issue(OP_POP, $urandom, $urandom);

		while (issued < REQUEST_TOTAL) begin
			quiet = ($urandom_range(0, 5) == 0);
			mode = $urandom_range(0, 9);
			if (mode < 7) begin
				foreach (key_pool[i]) key_pool[i] = $urandom;
				repeat ($urandom_range(20, 80)) begin
					sel = $urandom_range(0, 99);
					if (sel < 45) begin
						issue(OP_INSERT, pick_key(), pick_amount());
					end else if (sel < 70) begin
						issue(OP_QUERY, pick_key(), $urandom);
					end else if (sel < 98) begin
						issue(OP_POP, $urandom, $urandom);
					end else begin
						issue(OP_CLEAR, $urandom, $urandom);
					end
				end
			end else if (mode < 9) begin
				// fill, at times past capacity, then drain, often past empty
				repeat ($urandom_range(50, 80)) begin
					if ($urandom_range(0, 6) == 0) begin
						issue(OP_QUERY, last_key, $urandom);
					end else begin
						last_key = $urandom;
						issue(OP_INSERT, last_key, pick_amount());
					end
				end
				repeat ($urandom_range(5, 80)) issue(OP_POP, $urandom, $urandom);
			end else begin
				issue(OP_CLEAR, $urandom, $urandom);
			end
		end
		start <= 1'b0;

		wait_cycles = 0;
		while (outstanding != 0 && wait_cycles < 1000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (80) @(posedge clk);

		$display("Sent %0d requests: %0d inserts, %0d queries, %0d pops, %0d clears.",
			issued, op_tally[OP_INSERT], op_tally[OP_QUERY], op_tally[OP_POP],
			op_tally[OP_CLEAR]);
		$display("Compared %0d results; %0d inserts refused on a full table, %0d pops on empty.",
			checked, full_drops, empty_pops);
		if (errors == 0 && outstanding == 0) begin
			$display("TB_OK");
		end else begin
			if (outstanding != 0) begin
				$display("%0d expected results never arrived", outstanding);
			end
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("Run timed out");
		$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: accumulating_indexed_priority_queue.f
rtl/core/aipq_pkg.sv
rtl/core/accumulating_indexed_priority_queue.sv
tb/priority_queue_checker.sv
tb/accumulating_indexed_priority_queue_test.sv
